>>> sv/assert_macros.svh
// Assertion helpers used by the checker file kect_checker.sv.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KECT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KECT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/kect_pkg.sv
// ----------------------------------------------------------------------------
// kect_pkg
// Types and codes shared by the keyed error counter table.
// ----------------------------------------------------------------------------
package kect_pkg;

    localparam int APP_W   = 64;
    localparam int SVC_W   = 32;
    localparam int ERR_W   = 32;
    localparam int COUNT_W = 32;

    typedef enum logic [1:0] {
        ST_COUNTED = 2'd0,
        ST_FULL    = 2'd1,
        ST_DRAINED = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic                    mode;
        logic [APP_W-1:0]        in_app_id;
        logic [SVC_W-1:0]        in_service_code;
        logic signed [ERR_W-1:0] in_err_code;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic [COUNT_W-1:0]      hit_count;
        logic [APP_W-1:0]        out_app_id;
        logic [SVC_W-1:0]        out_service_code;
        logic signed [ERR_W-1:0] out_err_code;
        logic                    last;
    } rsp_t;

    typedef struct packed {
        logic [APP_W-1:0]        app_id;
        logic [SVC_W-1:0]        service_code;
        logic signed [ERR_W-1:0] err_code;
    } key_t;

    typedef struct packed {
        key_t               key;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

>>> sv/keyed_error_counter_table_core.sv
// ----------------------------------------------------------------------------
// keyed_error_counter_table_core
// Table of event counters keyed by application id, service code and error
// code, with a count request and a drain-and-clear request.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   request | into      | req_valid / req_stall | req (kect_pkg::req_t)
//   result  | out of    | rsp_valid / rsp_stall | rsp (kect_pkg::rsp_t)
//
// A count request compares the entries in order, as the memory feeds the match unit
// one entry a cycle, and is answered at the first hit or after the last entry.
// A drain reads (S_DRD), loads (S_DLD) and holds (S_DOUT) each entry until it is taken.
// Reset empties the table by clearing the entry count; the memory is not cleared.
// The block takes no request until the last result of the current one is taken,
// so a stalled result holds the whole block.
// ----------------------------------------------------------------------------
module keyed_error_counter_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  kect_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output kect_pkg::rsp_t rsp
);
    import kect_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_DRD  = 6'b000100,
        S_DLD  = 6'b001000,
        S_OUT  = 6'b010000,
        S_DOUT = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               pend_reg, pend_next;
    key_t               key_reg, key_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    entry_t             rd_data;

    logic               hit;
    logic [COUNT_W-1:0] next_count;
    logic               last_cmp;
    logic               full;

    kect_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    kect_match u_match (
        .key        (key_reg),
        .ent        (rd_data),
        .hit        (hit),
        .next_count (next_count)
    );

    assign last_cmp = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = pend_reg;
        key_next       = key_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_en          = 1'b0;
        wr_idx         = cmp_idx_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_idx         = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next.app_id       = req.in_app_id;
                    key_next.service_code = req.in_service_code;
                    // A positive error code counts as zero.
                    key_next.err_code     = req.in_err_code[ERR_W-1] ? req.in_err_code
                                                                     : '0;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (req.mode)
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next        = '0;
                            rsp_next.status = ST_EMPTY;
                            rsp_next.last   = 1'b1;
                            rsp_valid_next  = 1'b1;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_DRD;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Reads run one entry ahead of the compare.
                rd_en        = (idx_reg < count_reg);
                pend_next    = rd_en;
                cmp_idx_next = idx_reg[IDX_W-1:0];
                if (rd_en)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end

                if (pend_reg && hit)
                begin
                    wr_en             = 1'b1;
                    wr_idx            = cmp_idx_reg;
                    wr_data.key       = rd_data.key;
                    wr_data.count     = next_count;
                    rsp_next          = '0;
                    rsp_next.status   = ST_COUNTED;
                    rsp_next.hit_count = next_count;
                    rsp_next.last     = 1'b1;
                    rsp_valid_next    = 1'b1;
                    pend_next         = 1'b0;
                    state_next        = S_OUT;
                end
                else if ((count_reg == '0) || (pend_reg && last_cmp))
                begin
                    rsp_next        = '0;
                    rsp_next.last   = 1'b1;
                    rsp_valid_next  = 1'b1;
                    pend_next       = 1'b0;
                    state_next      = S_OUT;
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en              = 1'b1;
                        wr_idx             = count_reg[IDX_W-1:0];
                        wr_data.key        = key_reg;
                        wr_data.count      = COUNT_W'(1);
                        count_next         = count_reg + CNT_W'(1);
                        rsp_next.status    = ST_COUNTED;
                        rsp_next.hit_count = COUNT_W'(1);
                    end
                end
            end

            S_DRD:
            begin
                rd_en      = 1'b1;
                state_next = S_DLD;
            end

            S_DLD:
            begin
                rsp_next.status           = ST_DRAINED;
                rsp_next.hit_count        = rd_data.count;
                rsp_next.out_app_id       = rd_data.key.app_id;
                rsp_next.out_service_code = rd_data.key.service_code;
                rsp_next.out_err_code     = rd_data.key.err_code;
                rsp_next.last             = ((idx_reg + CNT_W'(1)) == count_reg);
                rsp_valid_next            = 1'b1;
                state_next                = S_DOUT;
            end

            S_DOUT:
            begin
                if (!rsp_stall)
                begin
                    rsp_valid_next = 1'b0;
                    if (rsp_reg.last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_DRD;
                    end
                end
            end

            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    rsp_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        key_reg     <= key_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sv/kect_table_mem.sv
// ----------------------------------------------------------------------------
// kect_table_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kect_table_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  kect_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output kect_pkg::entry_t rd_data
);
    import kect_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule

>>> sv/kect_match.sv
// ----------------------------------------------------------------------------
// kect_match
// Shared compare and saturating increment unit, applied to one entry a cycle.
// ----------------------------------------------------------------------------
module kect_match (
    input  kect_pkg::key_t                    key,
    input  kect_pkg::entry_t                  ent,
    output logic                              hit,
    output logic [kect_pkg::COUNT_W-1:0]      next_count
);
    import kect_pkg::*;

    assign hit        = (ent.key == key);
    assign next_count = (ent.count == {COUNT_W{1'b1}}) ? ent.count
                                                       : ent.count + COUNT_W'(1);

endmodule

>>> sv/kect_checker.sv
// ----------------------------------------------------------------------------
// kect_checker
// Port-level checks on the counter table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kect_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input kect_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input kect_pkg::rsp_t rsp
);
    import kect_pkg::*;

    // A stalled result keeps its contents.
    `KECT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

    // Once a request is taken the block is busy in the next cycle.
    `KECT_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request taken but block not busy")

    // No request is taken while a result waits.
    `KECT_ASSERT_IMPL(a_no_req_with_rsp, rsp_valid, req_stall, "request side open while a result waits")

    // Only drained entries may be followed by further results.
    `KECT_ASSERT_IMPL(a_single_last, rsp_valid && (rsp.status != ST_DRAINED), rsp.last, "single result not marked last")

    // After a non-final drained entry the drain continues.
    `KECT_ASSERT_NEXT(a_drain_continues, rsp_valid && !rsp_stall && !rsp.last, req_stall, "drain stopped before its last entry")

endmodule

bind keyed_error_counter_table_core kect_checker u_kect_checker (.*);
